// ===== hw/rtl/mcmq_pkg.sv =====
// mcmq_pkg: shared types and codes for the multi-channel mailbox queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mcmq_pkg;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_SEND   = 3'd1,
      CMD_RECV   = 3'd2,
      CMD_ADDREF = 3'd3,
      CMD_CLOSEP = 3'd4,
      CMD_CLOSE  = 3'd5,
      CMD_SETCAP = 3'd6,
      CMD_BAD    = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_BADID  = 3'd1,
      ST_CLOSED = 3'd2,
      ST_TOOBIG = 3'd3,
      ST_BADARG = 3'd4,
      ST_BLOCK  = 3'd5,
      ST_NOSLOT = 3'd6,
      ST_BUSY   = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_LOOKUP = 2'd1,
      FSM_EXEC   = 2'd2,
      FSM_REPLY  = 2'd3
   } fsm_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] mbox_id;
      logic [7:0]  capacity_value;
      logic [63:0] payload;
      logic [15:0] msg_size;
      logic [15:0] rx_limit;
      logic        is_send_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
      logic [63:0] data_out;
      logic [15:0] copy_length;
      logic        msg_ready;
      logic        room_left;
      logic [7:0]  capacity_now;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic lookup;
      logic exec;
      logic reply;
   } ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mcmq_ctrl.sv =====
// mcmq_ctrl: command sequencer of the mailbox queue
// depends on mcmq_pkg
`timescale 1ns / 1ps
`default_nettype none
module mcmq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output mcmq_pkg::ctl_type     ctl
);

   mcmq_pkg::fsm_type state_ff, state_in;

   // next state
   always_comb begin
      unique case (state_ff)
         mcmq_pkg::FSM_IDLE:   state_in = start ? mcmq_pkg::FSM_LOOKUP : mcmq_pkg::FSM_IDLE;
         mcmq_pkg::FSM_LOOKUP: state_in = mcmq_pkg::FSM_EXEC;
         mcmq_pkg::FSM_EXEC:   state_in = mcmq_pkg::FSM_REPLY;
         mcmq_pkg::FSM_REPLY:  state_in = mcmq_pkg::FSM_IDLE;
         default:              state_in = mcmq_pkg::FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl = '0;
      busy = 1'b1;
      unique case (state_ff)
         mcmq_pkg::FSM_IDLE: begin
            busy = 1'b0;
            ctl.load = start;
         end
         mcmq_pkg::FSM_LOOKUP: ctl.lookup = 1'b1;
         mcmq_pkg::FSM_EXEC:   ctl.exec = 1'b1;
         mcmq_pkg::FSM_REPLY:  ctl.reply = 1'b1;
         default:              busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mcmq_pkg::FSM_IDLE;
      else state_ff <= state_in;
   end

   // a word is taken only from idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> state_ff == mcmq_pkg::FSM_LOOKUP) else $error("load not followed");
   a_reply_once: assert property (@(posedge clock) disable iff (reset)
      ctl.reply |=> !ctl.reply) else $error("double reply");
   a_exec_then_reply: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> ctl.reply) else $error("exec without reply");

endmodule
`default_nettype wire

// ===== hw/rtl/mcmq_dp.sv =====
// mcmq_dp: channel table, ring memory and result register of the mailbox queue
// depends on mcmq_pkg
`timescale 1ns / 1ps
`default_nettype none
module mcmq_dp #(
   parameter int CHANNELS      = 16,
   parameter int SLOTS         = 16,
   parameter int DEFAULT_DEPTH = 8,
   parameter int MAX_BYTES     = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mcmq_pkg::ctl_type ctl,
   input  wire mcmq_pkg::req_type req_word,
   output logic                   rsp_strobe,
   output mcmq_pkg::rsp_type      rsp_word
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MD = CHANNELS * (2 ** PW);
   localparam int AW = (MD > 1) ? $clog2(MD) : 1;

   mcmq_pkg::req_type req_ff;
   logic [CHANNELS-1:0] open_ff;
   logic [31:0]  ident_ff [CHANNELS];
   logic [7:0]   sends_ff [CHANNELS];
   logic [7:0]   recvs_ff [CHANNELS];
   logic [7:0]   count_ff [CHANNELS];
   logic [7:0]   cap_ff   [CHANNELS];
   logic [PW-1:0] rptr_ff [CHANNELS];
   logic [PW-1:0] wptr_ff [CHANNELS];
   logic [31:0]  next_id_ff;

   // ring memory, read data registered
   logic [79:0] ring_mem [MD];
   logic [79:0] ring_rd_ff;

   logic [CW-1:0] slot_ff, slot_in;
   logic          hit_ff, hit_in;
   logic          rsp_strobe_ff;
   mcmq_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] cap_req8;
   logic       cap_ok;
   assign cap_req8 = req_ff.capacity_value;
   assign cap_ok = (cap_req8 != 8'd0) && ({24'd0, cap_req8} <= 32'(SLOTS));

   // lookup: first matching open slot, or first free slot for create
   always_comb begin
      hit_in  = 1'b0;
      slot_in = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (req_ff.command == mcmq_pkg::CMD_CREATE) begin
            if (!open_ff[i]) begin
               hit_in = 1'b1;
               slot_in = CW'(i);
            end
         end else if (open_ff[i] && ident_ff[i] == req_ff.mbox_id) begin
            hit_in = 1'b1;
            slot_in = CW'(i);
         end
      end
   end

   logic [AW-1:0] wr_addr;
   assign wr_addr = AW'({slot_ff, wptr_ff[slot_ff]} & {(CW+PW){1'b1}});

   // request capture and lookup result
   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_word;
      if (ctl.lookup) begin
         slot_ff <= slot_in;
         hit_ff  <= hit_in;
      end
   end

   // result word for the command in flight
   always_comb begin
      rsp_in = '0;
      rsp_in.status = mcmq_pkg::ST_OK;
      if (req_ff.command == mcmq_pkg::CMD_CREATE) begin
         if (!hit_ff) rsp_in.status = mcmq_pkg::ST_NOSLOT;
         else rsp_in.value = next_id_ff;
      end else if (req_ff.command == mcmq_pkg::CMD_BAD) begin
         rsp_in.status = mcmq_pkg::ST_BADARG;
      end else if (!hit_ff) begin
         rsp_in.status = mcmq_pkg::ST_BADID;
      end else begin
         case (req_ff.command)
            mcmq_pkg::CMD_SEND: begin
               if (recvs_ff[slot_ff] == 8'd0) rsp_in.status = mcmq_pkg::ST_CLOSED;
               else if ({16'd0, req_ff.msg_size} > 32'(MAX_BYTES))
                  rsp_in.status = mcmq_pkg::ST_TOOBIG;
               else if (count_ff[slot_ff] >= cap_ff[slot_ff])
                  rsp_in.status = mcmq_pkg::ST_BLOCK;
            end
            mcmq_pkg::CMD_RECV: begin
               if (count_ff[slot_ff] == 8'd0) rsp_in.status = mcmq_pkg::ST_BLOCK;
               else begin
                  rsp_in.data_out = ring_rd_ff[79:16];
                  rsp_in.value = {16'd0, ring_rd_ff[15:0]};
                  rsp_in.copy_length = (ring_rd_ff[15:0] < req_ff.rx_limit) ?
                                       ring_rd_ff[15:0] : req_ff.rx_limit;
               end
            end
            mcmq_pkg::CMD_SETCAP: begin
               if (!cap_ok) rsp_in.status = mcmq_pkg::ST_BADARG;
               else if (cap_req8 < count_ff[slot_ff]) rsp_in.status = mcmq_pkg::ST_BUSY;
            end
            default: rsp_in.status = mcmq_pkg::ST_OK;
         endcase
      end
   end

   // ring memory port
   always_ff @(posedge clock) begin
      if (ctl.exec && req_ff.command == mcmq_pkg::CMD_SEND &&
          rsp_in.status == mcmq_pkg::ST_OK)
         ring_mem[wr_addr] <= {req_ff.payload, req_ff.msg_size};
      if (ctl.lookup) ring_rd_ff <= ring_mem[AW'({slot_in, rptr_ff[slot_in]} & {(CW+PW){1'b1}})];
   end

   // table update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
         next_id_ff <= 32'd1;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            ident_ff[i] <= '0; sends_ff[i] <= '0; recvs_ff[i] <= '0;
            count_ff[i] <= '0; cap_ff[i] <= 8'(DEFAULT_DEPTH);
            rptr_ff[i] <= '0; wptr_ff[i] <= '0;
         end
      end else begin
         rsp_strobe_ff <= ctl.exec;
         if (ctl.exec) begin
            rsp_ff <= rsp_in;
            if (req_ff.command == mcmq_pkg::CMD_CREATE) begin
               if (hit_ff) begin
                  open_ff[slot_ff] <= 1'b1;
                  ident_ff[slot_ff] <= next_id_ff;
                  next_id_ff <= next_id_ff + 32'd1;
                  rptr_ff[slot_ff] <= '0; wptr_ff[slot_ff] <= '0;
                  count_ff[slot_ff] <= '0;
                  cap_ff[slot_ff] <= cap_ok ? cap_req8 : 8'(DEFAULT_DEPTH);
                  sends_ff[slot_ff] <= 8'd1; recvs_ff[slot_ff] <= 8'd1;
               end
            end else if (req_ff.command != mcmq_pkg::CMD_BAD && hit_ff) begin
               case (req_ff.command)
                  mcmq_pkg::CMD_SEND: begin
                     if (rsp_in.status == mcmq_pkg::ST_OK) begin
                        wptr_ff[slot_ff] <= (wptr_ff[slot_ff] == PW'(SLOTS - 1)) ?
                                            '0 : wptr_ff[slot_ff] + PW'(1);
                        count_ff[slot_ff] <= count_ff[slot_ff] + 8'd1;
                     end
                  end
                  mcmq_pkg::CMD_RECV: begin
                     if (rsp_in.status == mcmq_pkg::ST_OK) begin
                        rptr_ff[slot_ff] <= (rptr_ff[slot_ff] == PW'(SLOTS - 1)) ?
                                            '0 : rptr_ff[slot_ff] + PW'(1);
                        count_ff[slot_ff] <= count_ff[slot_ff] - 8'd1;
                     end
                  end
                  mcmq_pkg::CMD_ADDREF: begin
                     if (req_ff.is_send_end) begin
                        if (sends_ff[slot_ff] != 8'hFF) sends_ff[slot_ff] <= sends_ff[slot_ff] + 8'd1;
                     end else if (recvs_ff[slot_ff] != 8'hFF)
                        recvs_ff[slot_ff] <= recvs_ff[slot_ff] + 8'd1;
                  end
                  mcmq_pkg::CMD_CLOSEP: begin
                     if (req_ff.is_send_end) begin
                        if (sends_ff[slot_ff] != 8'd0) sends_ff[slot_ff] <= sends_ff[slot_ff] - 8'd1;
                        if (sends_ff[slot_ff] <= 8'd1 && recvs_ff[slot_ff] == 8'd0) begin
                           open_ff[slot_ff] <= 1'b0; ident_ff[slot_ff] <= '0;
                        end
                     end else begin
                        if (recvs_ff[slot_ff] != 8'd0) recvs_ff[slot_ff] <= recvs_ff[slot_ff] - 8'd1;
                        if (recvs_ff[slot_ff] <= 8'd1 && sends_ff[slot_ff] == 8'd0) begin
                           open_ff[slot_ff] <= 1'b0; ident_ff[slot_ff] <= '0;
                        end
                     end
                  end
                  mcmq_pkg::CMD_CLOSE: begin
                     open_ff[slot_ff] <= 1'b0; ident_ff[slot_ff] <= '0;
                  end
                  default: begin
                     if (rsp_in.status == mcmq_pkg::ST_OK) cap_ff[slot_ff] <= cap_req8;
                  end
               endcase
            end
         end
      end
   end

   // flags read from the table after the update
   always_comb begin
      rsp_word = rsp_ff;
      if (hit_ff && open_ff[slot_ff]) begin
         rsp_word.msg_ready    = count_ff[slot_ff] != 8'd0;
         rsp_word.room_left    = count_ff[slot_ff] < cap_ff[slot_ff];
         rsp_word.capacity_now = cap_ff[slot_ff];
      end else begin
         rsp_word.msg_ready    = 1'b0;
         rsp_word.room_left    = 1'b0;
         rsp_word.capacity_now = 8'd0;
      end
   end
   assign rsp_strobe = rsp_strobe_ff && ctl.reply;

   a_strobe_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ctl.reply) else $error("result outside reply");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.msg_ready |-> rsp_word.capacity_now != 8'd0)
      else $error("message in zero-capacity ring");
   a_nonrecv_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && req_ff.command != mcmq_pkg::CMD_RECV |-> rsp_word.data_out == 64'd0)
      else $error("stray payload");

endmodule
`default_nettype wire

// ===== hw/rtl/multi_channel_mailbox_queue.sv =====
// multi_channel_mailbox_queue: top level of the mailbox queue
// depends on mcmq_pkg, mcmq_ctrl, mcmq_dp
//
// A table of CHANNELS message channels, each a ring of SLOTS 64-bit words.
// Request channel: drive req_word and raise start while busy is low; the
// word is taken at that edge and busy rises.
// Result channel: rsp_word is valid for exactly one cycle with rsp_strobe,
// in the reply state, after the table update. The receiver cannot hold it off.
// Each command passes capture, channel lookup over the table with
// a registered ring memory read, table update and result; one command at a
// time, as the controller takes no start until it is back in idle.
// Reset clears all channels, sets capacities to DEFAULT_DEPTH and the id
// counter to one. Ring contents are not cleared; a read only hits
// written entries.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_mailbox_queue #(
   parameter int CHANNELS      = 16,
   parameter int SLOTS         = 16,
   parameter int DEFAULT_DEPTH = 8,
   parameter int MAX_BYTES     = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mcmq_pkg::req_type req_word,
   output logic                   rsp_strobe,
   output mcmq_pkg::rsp_type      rsp_word
);

   mcmq_pkg::ctl_type ctl;

   mcmq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .ctl(ctl)
   );

   mcmq_dp #(
      .CHANNELS(CHANNELS), .SLOTS(SLOTS),
      .DEFAULT_DEPTH(DEFAULT_DEPTH), .MAX_BYTES(MAX_BYTES)
   ) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

endmodule
`default_nettype wire
